/* design/rafilt_pkg.sv */
package rafilt_pkg;

   // width of the average field on the result channel
   localparam int AVG_W = 12;

   // status codes on the result channel
   localparam logic STATUS_VALID   = 1'b0;
   localparam logic STATUS_FILLING = 1'b1;

endpackage

/* design/rafilt_ram.sv */
module rafilt_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rafilt_front.sv */
module rafilt_front import rafilt_pkg::*; #(
   parameter int DEPTH       = 8,
   parameter int SAMPLE_BITS = 12,
   parameter int SUM_W       = 15,
   parameter int IDX_W       = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   push,
   output logic [SUM_W-1:0]       push_sum,
   output logic                   push_status
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

   logic                   accept;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   full_ff, full_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   byp_ff, byp_in;
   logic [SAMPLE_BITS-1:0] byp_data_ff;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [SAMPLE_BITS-1:0] oldest;
   logic [SUM_W-1:0]       sum_less;
   logic                   wrap;

   assign accept = req_valid && !req_stall;

   // ring buffer, read one slot ahead so the leaving sample is ready
   rafilt_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_sample),
      .rd_addr (slot_in),
      .rd_data (rd_data)
   );

   // a write to the slot being read lands after the read, so forward it
   assign oldest = byp_ff ? byp_data_ff : rd_data;

   always_comb begin
      wrap     = (slot_ff == LAST_SLOT);
      sum_less = full_ff ? (sum_ff - SUM_W'(oldest)) : sum_ff;
      slot_in  = slot_ff;
      full_in  = full_ff;
      sum_in   = sum_ff;
      if (accept) begin
         slot_in = wrap ? '0 : slot_ff + IDX_W'(1);
         full_in = full_ff | wrap;
         sum_in  = sum_less + SUM_W'(req_sample);
      end
      byp_in = accept && (slot_in == slot_ff);
   end

   assign push        = accept;
   assign push_sum    = full_in ? sum_in : '0;
   assign push_status = full_in ? STATUS_VALID : STATUS_FILLING;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         full_ff <= 1'b0;
         sum_ff  <= '0;
         byp_ff  <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         full_ff <= full_in;
         sum_ff  <= sum_in;
         byp_ff  <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= req_sample;
   end

endmodule

/* design/rafilt_queue.sv */
module rafilt_queue #(
   parameter int SUM_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [SUM_W-1:0] push_sum,
   input  logic             push_status,
   input  logic             pop,
   output logic             q_valid,
   output logic             q_full,
   output logic [SUM_W-1:0] q_sum,
   output logic             q_status
);

   localparam int ENTRIES = 2;
   localparam int PTR_W   = 1;
   localparam int CNT_W   = 2;

   logic [SUM_W-1:0] sum_ff [ENTRIES];
   logic             sts_ff [ENTRIES];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign q_valid  = (count_ff != '0);
   assign q_full   = (count_ff == CNT_W'(ENTRIES));
   assign q_sum    = sum_ff[rd_ptr_ff];
   assign q_status = sts_ff[rd_ptr_ff];
   assign do_pop   = pop && q_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         sum_ff[wr_ptr_ff] <= push_sum;
         sts_ff[wr_ptr_ff] <= push_status;
      end
   end

endmodule

/* design/rafilt_back.sv */
module rafilt_back import rafilt_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int SUM_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  logic [SUM_W-1:0] q_sum,
   input  logic             q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [AVG_W-1:0] rsp_average,
   output logic             rsp_status
);

   localparam int LOG_D = $clog2(DEPTH);
   localparam int SHIFT = SUM_W + LOG_D;
   localparam int MW    = SUM_W + 1;
   localparam int KW    = (MW + 1) / 2;
   localparam int HW    = MW - KW;
   localparam int LO_W  = SUM_W + KW;
   localparam int HI_W  = SUM_W + HW;
   localparam int PW    = SUM_W + MW;
   localparam int QW    = PW - SHIFT;
   // ceil(2^SHIFT / DEPTH), exact floor division for every sum below 2^SUM_W
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
   localparam logic [KW-1:0] RECIP_LO = RECIP[KW-1:0];
   localparam logic [HW-1:0] RECIP_HI = RECIP[MW-1:KW];

   logic                adv;
   logic                vld1_ff, vld2_ff;
   logic [LO_W-1:0]     lo_ff, lo_in;
   logic [HI_W-1:0]     hi_ff, hi_in;
   logic                sts1_ff, sts2_ff;
   logic [PW-1:0]       prod;
   logic [QW-1:0]       quo;
   logic [QW+AVG_W-1:0] quo_wide;
   logic [AVG_W-1:0]    avg_ff, avg_in;

   // whole pipe moves unless the result register is held
   assign adv = !(vld2_ff && rsp_stall);
   assign pop = adv && q_valid;

   // sum times reciprocal, split into two partial products
   assign lo_in = LO_W'(q_sum) * LO_W'(RECIP_LO);
   assign hi_in = HI_W'(q_sum) * HI_W'(RECIP_HI);

   // recombine and keep the quotient bits
   assign prod     = {hi_ff, {KW{1'b0}}} + PW'(lo_ff);
   assign quo      = prod[PW-1:SHIFT];
   assign quo_wide = {{AVG_W{1'b0}}, quo};
   assign avg_in   = quo_wide[AVG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= q_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         sts1_ff <= q_status;
         avg_ff  <= avg_in;
         sts2_ff <= sts1_ff;
      end
   end

   assign rsp_valid   = vld2_ff;
   assign rsp_average = avg_ff;
   assign rsp_status  = sts2_ff;

endmodule

/* design/running_average_filter.sv */
// path: an accepted item is written into the queue, then registered in the product
// stage and then in the output register; a result stall can hold it in between
// throughput: one item per cycle unless req_stall is high; ring buffer and running sum
// update together; divide by DEPTH is a reciprocal multiply over two pipeline stages
// reset: synchronous active high, clears slot, fill flag, running sum, queue and pipe
// valids; the sample ring buffer holds whatever it had, its data never used before written
module running_average_filter import rafilt_pkg::*; #(
   parameter int DEPTH       = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   // average result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [AVG_W-1:0]       rsp_average,
   output logic                   rsp_status
);

   // full-width running sum: DEPTH samples of SAMPLE_BITS each
   localparam int SUM_W = SAMPLE_BITS + $clog2(DEPTH);
   // ring buffer slot index, at least one bit
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // front to queue
   logic             push;
   logic [SUM_W-1:0] push_sum;
   logic             push_status;

   // queue to back
   logic             q_valid;
   logic             q_full;
   logic [SUM_W-1:0] q_sum;
   logic             q_status;
   logic             pop;

   // input side stalls only when the queue has no free entry
   assign req_stall = q_full;

   // front: ring buffer write, running sum and fill tracking per item
   rafilt_front #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .push        (push),
      .push_sum    (push_sum),
      .push_status (push_status)
   );

   // two-entry queue decouples the sum update from the divider
   rafilt_queue #(
      .SUM_W (SUM_W)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_sum    (push_sum),
      .push_status (push_status),
      .pop         (pop),
      .q_valid     (q_valid),
      .q_full      (q_full),
      .q_sum       (q_sum),
      .q_status    (q_status)
   );

   // back: sum / DEPTH by reciprocal multiply, second stage is the output register
   rafilt_back #(
      .DEPTH       (DEPTH),
      .SUM_W       (SUM_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_sum       (q_sum),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average),
      .rsp_status  (rsp_status)
   );

`ifndef ASSERT_OFF
   // a window still filling always reports a zero average
   a_filling_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FILLING) |-> (rsp_average == '0))
      else $error("nonzero average while window filling");

   // the front only forwards a zero sum for a filling window
   a_queue_zero: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_status == STATUS_FILLING) |-> (q_sum == '0))
      else $error("nonzero sum queued while window filling");

   // a full queue must present an item to the divider
   a_full_has_item: assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_valid)
      else $error("queue full without a valid head item");
`endif

endmodule
